// ===== rtl/nmea_sentence_framer_top_assert.svh =====
// assertion macros for the nmea sentence framer
// expects clk and rst_n in the scope of the module that uses them
`ifndef NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH

// checked on every rising edge outside reset
`define NSF_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every rising edge, reset included
`define NSF_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/nsf_pkg.sv =====
// shared types, codes and helper functions of the nmea sentence framer
// no dependencies
package nsf_pkg;

  localparam logic [7:0] MAX_PAYLOAD = 8'd128;
  localparam logic [3:0] ADDR_LEN    = 4'd5;
  localparam logic [3:0] ADDR_SAT    = 4'd15;
  localparam logic [4:0] FIELD_SAT   = 5'd31;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_PAYLOAD = 3'd1;
  localparam logic [2:0] PH_DIG_HI  = 3'd2;
  localparam logic [2:0] PH_DIG_LO  = 3'd3;
  localparam logic [2:0] PH_CR      = 3'd4;
  localparam logic [2:0] PH_LF      = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_FIELDS = 3'd2;
  localparam logic [2:0] ST_TYPE   = 3'd3;
  localparam logic [2:0] ST_FRAME  = 3'd4;

  localparam logic [1:0] TY_GGA  = 2'd0;
  localparam logic [1:0] TY_RMC  = 2'd1;
  localparam logic [1:0] TY_GSA  = 2'd2;
  localparam logic [1:0] TY_NONE = 2'd3;

  localparam logic [23:0] NAME_GGA = "GGA";
  localparam logic [23:0] NAME_RMC = "RMC";
  localparam logic [23:0] NAME_GSA = "GSA";

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] REG_MIN_LEN    = 3'h0;
  localparam logic [2:0] REG_MIN_FIELDS = 3'h4;

  typedef struct packed {
    logic [7:0] min_payload_len;
    logic [4:0] min_field_count;
  } nsf_cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] sentence_type;
    logic [7:0] payload_len;
    logic [7:0] calc_checksum;
    logic [7:0] rx_checksum;
    logic [4:0] field_count;
  } nsf_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nsf_hex_t;

  function automatic nsf_hex_t hex_decode(input logic [7:0] c);
    nsf_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - 8'h30);
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - 8'h37);
    end else if (c >= "a" && c <= "f") begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [4:0] fields_of(input logic [4:0] commas);
    return (commas >= 5'd30) ? FIELD_SAT : 5'(commas + 5'd1);
  endfunction

endpackage

// ===== rtl/nsf_stream_if.sv =====
// valid/ready channel interfaces for received bytes and sentence results
// no dependencies
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface nsf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] sentence_type;
  logic [7:0] payload_len;
  logic [7:0] calc_checksum;
  logic [7:0] rx_checksum;
  logic [4:0] field_count;

  modport source(output valid, output status, output sentence_type, output payload_len,
                 output calc_checksum, output rx_checksum, output field_count,
                 input ready);
  modport sink(input valid, input status, input sentence_type, input payload_len,
               input calc_checksum, input rx_checksum, input field_count,
               output ready);
endinterface

// ===== rtl/nsf_apb_regs.sv =====
// apb configuration registers: minimum payload length and minimum field count
// depends on nsf_pkg
module nsf_apb_regs
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output nsf_cfg_t    cfg
);

  logic [7:0] min_len_r;
  logic [4:0] min_fields_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r    <= 8'd6;
      min_fields_r <= 5'd5;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_MIN_FIELDS[2]) begin
        min_fields_r <= cfg_pwdata[4:0];
      end else begin
        min_len_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_MIN_LEN:    cfg_prdata = {24'd0, min_len_r};
      REG_MIN_FIELDS: cfg_prdata = {27'd0, min_fields_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.min_payload_len = min_len_r;
  assign cfg.min_field_count = min_fields_r;

endmodule

// ===== rtl/nsf_parser.sv =====
// sentence state machine: framing, checksum, field count and address tracking
// depends on nsf_pkg and nmea_sentence_framer_top_assert.svh
`include "nmea_sentence_framer_top_assert.svh"

module nsf_parser
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  nsf_cfg_t    cfg,
  output logic        emit,
  output nsf_result_t res
);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [4:0] comma_r, comma_nxt;
  logic [3:0] alen_r, alen_nxt;
  logic [3:0] dhi_r, dhi_nxt;
  logic       bad_r, bad_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] addr_r [3];
  logic       addr_we;
  logic [1:0] addr_idx;
  logic [1:0] addr_type;
  logic [4:0] fields;
  logic [2:0] status;
  logic [1:0] stype;
  nsf_hex_t   hx;

  assign fields   = fields_of(comma_r);
  assign addr_idx = 2'(alen_r - 4'd2);
  assign hx       = hex_decode(rx_byte);

  always_comb begin
    addr_type = TY_NONE;
    if (alen_r == ADDR_LEN) begin
      if ({addr_r[0], addr_r[1], addr_r[2]} == NAME_GGA) begin
        addr_type = TY_GGA;
      end else if ({addr_r[0], addr_r[1], addr_r[2]} == NAME_RMC) begin
        addr_type = TY_RMC;
      end else if ({addr_r[0], addr_r[1], addr_r[2]} == NAME_GSA) begin
        addr_type = TY_GSA;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    comma_nxt = comma_r;
    alen_nxt  = alen_r;
    dhi_nxt   = dhi_r;
    bad_nxt   = bad_r;
    sum_nxt   = sum_r;
    addr_we   = 1'b0;
    emit      = 1'b0;
    status    = ST_FRAME;
    stype     = TY_NONE;
    case (phase_r)
      PH_PAYLOAD: begin
        if (rx_byte == CH_DOLLAR) begin
          emit = 1'b1;
        end else if (rx_byte == CH_STAR) begin
          if (len_r >= cfg.min_payload_len) begin
            phase_nxt = PH_DIG_HI;
          end else begin
            emit = 1'b1;
          end
        end else if (len_r >= MAX_PAYLOAD) begin
          emit = 1'b1;
        end else begin
          len_nxt = len_r + 8'd1;
          xor_nxt = xor_r ^ rx_byte;
          if (rx_byte == CH_COMMA) begin
            if (comma_r != FIELD_SAT) begin
              comma_nxt = comma_r + 5'd1;
            end
          end else if (comma_r == 5'd0) begin
            addr_we = (alen_r >= 4'd2) && (alen_r < ADDR_LEN);
            if (alen_r != ADDR_SAT) begin
              alen_nxt = alen_r + 4'd1;
            end
          end
        end
      end
      PH_DIG_HI: begin
        dhi_nxt   = hx.val;
        bad_nxt   = bad_r | !hx.ok;
        phase_nxt = PH_DIG_LO;
      end
      PH_DIG_LO: begin
        sum_nxt   = {dhi_r, hx.val};
        bad_nxt   = bad_r | !hx.ok;
        phase_nxt = PH_CR;
      end
      PH_CR: begin
        if (rx_byte == CH_CR) begin
          phase_nxt = PH_LF;
        end else begin
          emit = 1'b1;
        end
      end
      PH_LF: begin
        emit = 1'b1;
        if (rx_byte == CH_LF && !bad_r) begin
          stype = addr_type;
          if (fields < cfg.min_field_count) begin
            status = ST_FIELDS;
          end else if (sum_r != xor_r) begin
            status = ST_SUM;
          end else if (addr_type == TY_NONE) begin
            status = ST_TYPE;
          end else begin
            status = ST_OK;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == CH_DOLLAR) begin
          phase_nxt = PH_PAYLOAD;
          len_nxt   = 8'd0;
          xor_nxt   = 8'd0;
          comma_nxt = 5'd0;
          alen_nxt  = 4'd0;
          dhi_nxt   = 4'd0;
          bad_nxt   = 1'b0;
          sum_nxt   = 8'd0;
        end
      end
    endcase
    if (emit) begin
      phase_nxt = PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= 8'd0;
      xor_r   <= 8'd0;
      comma_r <= 5'd0;
      alen_r  <= 4'd0;
      dhi_r   <= 4'd0;
      bad_r   <= 1'b0;
      sum_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      comma_r <= comma_nxt;
      alen_r  <= alen_nxt;
      dhi_r   <= dhi_nxt;
      bad_r   <= bad_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // only the third to fifth address characters are kept
  always_ff @(posedge clk) begin
    if (step && addr_we) begin
      addr_r[addr_idx] <= rx_byte;
    end
  end

  assign res.status        = status;
  assign res.sentence_type = stype;
  assign res.payload_len   = len_r;
  assign res.calc_checksum = xor_r;
  assign res.rx_checksum   = sum_r;
  assign res.field_count   = fields;

  `NSF_ASSERT_CLK(a_hunt_silent, (step && phase_r == PH_HUNT) |-> !emit, "result while hunting")
  `NSF_ASSERT_CLK(a_emit_to_hunt, (step && emit) |=> (phase_r == PH_HUNT), "no return to hunt")
  `NSF_ASSERT_CLK(a_len_bound, len_r <= MAX_PAYLOAD, "payload length overflow")
  `NSF_ASSERT_CLK(a_payload_clean, (phase_r == PH_PAYLOAD) |-> !bad_r, "stale bad digit flag")
  `NSF_ASSERT_ANY(a_reset_hunt, !rst_n |=> (phase_r == PH_HUNT), "reset did not enter hunt")

endmodule

// ===== rtl/nmea_sentence_framer_top.sv =====
// nmea sentence framer: byte in, one classification beat per sentence out
// depends on nsf_pkg, nsf_stream_if, nsf_apb_regs and nsf_parser
//
// in_ch carries one received character per beat. out_ch gives one beat when a
// sentence ends on its line feed, or at once when a framing fault is seen
// (start inside a frame, overflow, short frame, missing cr or lf). other bytes
// give no beat.
// the block takes one byte per cycle unless a result waits for a full output
// register. a byte is registered in the input register; its result is then
// loaded into the output register when the parser steps on the byte.
// out_ch is driven from a register. while a result waits there, one more
// byte is taken and any bytes that give no result keep moving; a byte that
// would give a result holds in the input register until the output is free,
// and in_ch.ready then drops.
// the cfg_ apb port holds min_payload_len at 0x0 and min_field_count at 0x4;
// the user must write it only while the framer is idle; the block does not enforce this.
// synchronous reset: the framer hunts for a start character, both channels
// are empty, and the registers return to 6 and 5.
module nmea_sentence_framer_top
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  nsf_in_if.sink      in_ch,
  nsf_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  nsf_cfg_t    cfg;
  nsf_result_t res;
  nsf_result_t out_res_r;
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        out_vld_r, out_vld_nxt;
  logic        emit;
  logic        out_free;
  logic        adv;
  logic        in_take;

  nsf_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  nsf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .emit    (emit),
    .res     (res)
  );

  assign out_free    = !out_vld_r || out_ch.ready;
  assign adv         = in_vld_r && (!emit || out_free);
  assign in_ch.ready = !in_vld_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.sentence_type = out_res_r.sentence_type;
  assign out_ch.payload_len   = out_res_r.payload_len;
  assign out_ch.calc_checksum = out_res_r.calc_checksum;
  assign out_ch.rx_checksum   = out_res_r.rx_checksum;
  assign out_ch.field_count   = out_res_r.field_count;

endmodule

// ===== tb/nsf_tb_pkg.sv =====
// sentence scoreboard for the nmea sentence framer: byte-level predictor and result checks
// depends on nsf_pkg for the result struct, character and status codes
package nsf_tb_pkg;
  import nsf_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  class sentence_scoreboard;
    logic [7:0]  min_len;
    logic [4:0]  min_fields;
    logic [2:0]  phase;
    logic [7:0]  length;
    logic [7:0]  running_sum;
    logic [7:0]  parsed_sum;
    logic [4:0]  commas;
    logic [7:0]  addr[5];
    logic [3:0]  addr_len;
    logic [3:0]  high_nibble;
    bit          digit_bad;
    nsf_result_t pending_results[$];
    int          errors;
    int          bytes_seen;
    int          beats_seen;

    function new();
      min_len    = 8'd6;
      min_fields = 5'd5;
      phase      = PH_HUNT;
      errors     = 0;
      bytes_seen = 0;
      beats_seen = 0;
      start_frame();
    endfunction

    function void start_frame();
      length      = 8'd0;
      running_sum = 8'd0;
      parsed_sum  = 8'd0;
      commas      = 5'd0;
      addr_len    = 4'd0;
      high_nibble = 4'd0;
      digit_bad   = 1'b0;
    endfunction

    function logic [4:0] field_total();
      return (commas >= 5'd30) ? FIELD_SAT : commas + 5'd1;
    endfunction

    function logic [1:0] talker_type();
      logic [23:0] name;
      if (addr_len != ADDR_LEN) return TY_NONE;
      name = {addr[2], addr[3], addr[4]};
      if (name == NAME_GGA) return TY_GGA;
      if (name == NAME_RMC) return TY_RMC;
      if (name == NAME_GSA) return TY_GSA;
      return TY_NONE;
    endfunction

    function void close_frame(logic [2:0] status, logic [1:0] kind);
      nsf_result_t r;
      r.status        = status;
      r.sentence_type = kind;
      r.payload_len   = length;
      r.calc_checksum = running_sum;
      r.rx_checksum   = parsed_sum;
      r.field_count   = field_total();
      pending_results.push_back(r);
      phase = PH_HUNT;
    endfunction

    function void take_byte(logic [7:0] c);
      logic [3:0] v;
      logic [1:0] kind;
      bytes_seen++;
      case (phase)
        PH_PAYLOAD: begin
          if (c == CH_DOLLAR) begin
            close_frame(ST_FRAME, TY_NONE);
          end else if (c == CH_STAR) begin
            if (length >= min_len) phase = PH_DIG_HI;
            else close_frame(ST_FRAME, TY_NONE);
          end else if (length >= MAX_PAYLOAD) begin
            close_frame(ST_FRAME, TY_NONE);
          end else begin
            length++;
            running_sum ^= c;
            if (c == CH_COMMA) begin
              if (commas < FIELD_SAT) commas++;
            end else if (commas == 5'd0) begin
              if (addr_len < ADDR_LEN) addr[addr_len] = c;
              if (addr_len < ADDR_SAT) addr_len++;
            end
          end
        end
        PH_DIG_HI: begin
          if (!hex_digit(c, v)) digit_bad = 1'b1;
          high_nibble = v;
          phase = PH_DIG_LO;
        end
        PH_DIG_LO: begin
          if (!hex_digit(c, v)) digit_bad = 1'b1;
          parsed_sum = {high_nibble, v};
          phase = PH_CR;
        end
        PH_CR: begin
          if (c == CH_CR) phase = PH_LF;
          else close_frame(ST_FRAME, TY_NONE);
        end
        PH_LF: begin
          kind = talker_type();
          if (c != CH_LF || digit_bad) close_frame(ST_FRAME, TY_NONE);
          else if (field_total() < min_fields) close_frame(ST_FIELDS, kind);
          else if (parsed_sum != running_sum) close_frame(ST_SUM, kind);
          else if (kind == TY_NONE) close_frame(ST_TYPE, kind);
          else close_frame(ST_OK, kind);
        end
        default: begin
          phase = PH_HUNT;
          if (c == CH_DOLLAR) begin
            start_frame();
            phase = PH_PAYLOAD;
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %0d, expected %0d", beats_seen, name, got, want));
    endtask

    task check_result(nsf_result_t got);
      nsf_result_t want;
      beats_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing pending (status %0d)",
                         beats_seen, got.status));
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("sentence_type", 8'(got.sentence_type), 8'(want.sentence_type));
      compare_field("payload_len", got.payload_len, want.payload_len);
      compare_field("calc_checksum", got.calc_checksum, want.calc_checksum);
      compare_field("rx_checksum", got.rx_checksum, want.rx_checksum);
      compare_field("field_count", 8'(got.field_count), 8'(want.field_count));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// top-level testbench for nmea_sentence_framer_top: sends directed and random sentences,
// writes the apb registers between phases and checks every result beat
// depends on nsf_pkg, nsf_stream_if, the framer rtl and nsf_tb_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsf_pkg::*;
  import nsf_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        holding = 1'b0;
  int          recv_stall_pct = 0;
  int          send_idle_pct = 0;

  sentence_scoreboard sb;

  nsf_in_if  in_ch();
  nsf_out_if out_ch();

  nmea_sentence_framer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // result beats are checked before the byte of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.status, out_ch.sentence_type, out_ch.payload_len,
                         out_ch.calc_checksum, out_ch.rx_checksum, out_ch.field_count});
      if (in_ch.valid && in_ch.ready) sb.take_byte(in_ch.rx_byte);
    end
    out_ch.ready <= rst_n && !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'(8'h30 + n);
    return lower ? 8'(8'h61 + n - 4'd10) : 8'(8'h41 + n - 4'd10);
  endfunction

  function automatic byte_q_t sum_tail(input logic [7:0] s, input bit lower);
    byte_q_t t;
    t = {hex_char(s[7:4], lower), hex_char(s[3:0], lower), CH_CR, CH_LF};
    return t;
  endfunction

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] xor_of(input byte_q_t q);
    logic [7:0] x;
    x = 8'd0;
    foreach (q[i]) x ^= q[i];
    return x;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom_range(255)); while (hex_digit(c, v));
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic send_frame(input byte_q_t body, input byte_q_t tail);
    send_byte(CH_DOLLAR);
    send_bytes(body);
    send_byte(CH_STAR);
    send_bytes(tail);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic hold_ready(input int cycles);
    holding <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding <= 1'b0;
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == REG_MIN_LEN) sb.min_len = data[7:0];
    else sb.min_fields = data[4:0];
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== data)
      sb.report($sformatf("register 0x%0h read back 0x%0h, wrote 0x%0h", addr, rd, data));
  endtask

  task automatic random_sentence();
    byte_q_t     body;
    byte_q_t     tail;
    logic [7:0]  c;
    logic [7:0]  sum;
    logic [23:0] name;
    int          kind;
    int          plen;
    int          alen;
    int          comma_pct;
    int          ty;
    int          cut;
    bit          lower;
    kind = $urandom_range(99);
    if (kind >= 90 && kind < 95) begin
      repeat ($urandom_range(1, 8)) begin
        c = 8'($urandom_range(255));
        if (c == CH_DOLLAR && $urandom_range(1)) c = CH_STAR;
        send_byte(c);
      end
      return;
    end
    lower     = 1'($urandom_range(1));
    alen      = ($urandom_range(7) == 0) ? $urandom_range(0, 17) : 5;
    comma_pct = (kind >= 95) ? $urandom_range(0, 3) : $urandom_range(15, 45);
    plen      = ($urandom_range(29) == 0) ? 128 : $urandom_range(6, 40);
    if (kind >= 85 && kind < 90) plen = 128 + $urandom_range(1, 5);
    else if (kind >= 80 && kind < 85)
      plen = (sb.min_len > 0) ? $urandom_range(0, sb.min_len - 1) : 0;
    else if (plen < sb.min_len) plen = sb.min_len;
    ty   = $urandom_range(3);
    name = (ty == 0) ? NAME_GGA : (ty == 1) ? NAME_RMC : NAME_GSA;
    for (int i = 0; i < plen; i++) begin
      if (i < alen) begin
        if (alen == 5 && i >= 2 && ty < 3) c = name[8*(4-i) +: 8];
        else c = 8'(8'h41 + $urandom_range(25));
      end else if (i == alen || $urandom_range(99) < comma_pct) begin
        c = CH_COMMA;
      end else if ($urandom_range(15) == 0) begin
        do c = 8'($urandom_range(255)); while (c == CH_DOLLAR || c == CH_STAR);
      end else begin
        c = ($urandom_range(10) == 0) ? 8'h2E : 8'(8'h30 + $urandom_range(9));
      end
      body.push_back(c);
    end
    sum = xor_of(body);
    if (kind >= 55 && kind < 65) sum ^= 8'($urandom_range(1, 255));
    tail = sum_tail(sum, lower);
    if (kind >= 65 && kind < 70) begin
      cut = $urandom_range(2);
      if (cut != 1) tail[0] = non_hex();
      if (cut != 0) tail[1] = non_hex();
    end else if (kind >= 70 && kind < 73) begin
      do tail[2] = 8'($urandom_range(255)); while (tail[2] == CH_CR);
    end else if (kind >= 73 && kind < 75) begin
      do tail[3] = 8'($urandom_range(255)); while (tail[3] == CH_LF);
    end else if (kind >= 75 && kind < 80) begin
      cut = $urandom_range(0, body.size());
      while (body.size() > cut) void'(body.pop_back());
      body.push_back(CH_DOLLAR);
    end
    send_frame(body, tail);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    byte_q_t q;
    byte_q_t t;
    int      lens[6];
    int      flds[6];
    int      b0;
    int      r0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = 3'd0;
    cfg_pwdata    = 32'd0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sentences under the reset settings
    q = to_bytes("GPGGA,1,2,3,4");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q = to_bytes("GNRMC,a,b,c,d,e");
    send_frame(q, sum_tail(xor_of(q), 1'b1));
    q = to_bytes("GPGSA,,,,");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q = to_bytes("GPXYZ,1,2,3,4");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q = to_bytes("GPGG,1,2,3,4");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q = to_bytes("GPGGAX,1,2,3,4");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q = to_bytes("GPGGA,1,2,3");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q = {to_bytes("GPGSA,"), 8'h00, CH_CR, CH_LF, 8'hFF, 8'h80, to_bytes(",1,2,3")};
    send_frame(q, sum_tail(xor_of(q), 1'b1));
    q = to_bytes("GPGGA,1,2,3,4");
    send_frame(q, sum_tail(xor_of(q) ^ 8'h5A, 1'b0));
    t = sum_tail(xor_of(q), 1'b0);
    t[0] = "G";
    send_frame(q, t);
    t = sum_tail(xor_of(q), 1'b0);
    t[1] = ":";
    send_frame(q, t);
    t = sum_tail(xor_of(q), 1'b0);
    t[2] = "X";
    send_frame(q, t);
    t[2] = CH_CR;
    t[3] = CH_CR;
    send_frame(q, t);
    send_bytes(to_bytes("$GPGGA,1,$"));
    q = to_bytes("GPGG");
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    q.delete();
    send_frame(q, sum_tail(8'd0, 1'b0));
    q = to_bytes("GPRMC");
    while (q.size() < 129) q.push_back(CH_COMMA);
    send_frame(q, sum_tail(xor_of(q), 1'b0));
    void'(q.pop_back());
    send_frame(q, sum_tail(xor_of(q), 1'b1));
    send_bytes({8'h00, 8'hFF, 8'h55, 8'hAA, CH_STAR, CH_CR, CH_LF});

    // random phases over register settings and idle patterns
    lens = '{0, 128, 6, 3, 20, 0};
    flds = '{0, 31, 5, 1, 12, 0};
    lens[5] = $urandom_range(128);
    flds[5] = $urandom_range(31);
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      cfg_write(REG_MIN_LEN, 32'(lens[p]));
      cfg_write(REG_MIN_FIELDS, 32'(flds[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 59;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct <= 19;
        end
      endcase
      if (p == 0) begin
        fork
          hold_ready(300);
        join_none
      end
      b0 = sb.bytes_seen;
      r0 = sb.beats_seen;
      while (sb.bytes_seen - b0 < 60 || sb.beats_seen - r0 < 2) begin
        if ($urandom_range(24) == 0) wait_drained();
        random_sentence();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
